[sv/itra_pkg.sv]
package itra_pkg;

   localparam int VALUE_W     = 32;
   localparam int RADIX_W     = 6;
   localparam int CHAR_W      = 7;
   localparam int MAX_DIGITS  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int BIT_CNT_W   = $clog2(VALUE_W);

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] DECIMAL     = 6'd10;
   localparam logic [RADIX_W-1:0] DIGIT_MAX   = 6'd35;
   localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;

   typedef struct packed {
      logic [VALUE_W-1:0] magnitude;
      logic [RADIX_W-1:0] base;
      logic               sign;
   } itra_job_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [RADIX_W-1:0] c;
      c = (d > DIGIT_MAX) ? DIGIT_MAX : d;
      if (c < DIGIT_TEN) begin
         return CHAR_ZERO + {1'b0, c};
      end else begin
         return CHAR_A + {1'b0, c - DIGIT_TEN};
      end
   endfunction

endpackage

[sv/itra_ifs.sv]
interface itra_req_if;
   logic                          valid;
   logic                          ready;
   logic [itra_pkg::VALUE_W-1:0]  value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface itra_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [itra_pkg::CHAR_W-1:0]   char_code;
   logic                          last_char;
   modport source (output valid, output char_code, output last_char, input ready);
   modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface itra_csr_if;
   logic                          valid;
   logic                          ready;
   logic [itra_pkg::RADIX_W-1:0]  radix;
   modport source (output valid, output radix, input ready);
   modport sink (input valid, input radix, output ready);
endinterface

[sv/itra_front.sv]
module itra_front (
   input  logic                   clock,
   input  logic                   reset,
   itra_req_if.sink               req,
   itra_csr_if.sink               csr,
   input  logic                   queue_full,
   output logic                   push,
   output itra_pkg::itra_job_type job
);

   logic [itra_pkg::RADIX_W-1:0] radix_ff;
   logic [itra_pkg::RADIX_W-1:0] base;
   logic                         sign;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= itra_pkg::RADIX_RESET;
      end else if (csr.valid && csr.ready) begin
         radix_ff <= csr.radix;
      end
   end

   assign csr.ready = 1'b1;
   assign req.ready = !queue_full;
   assign push      = req.valid && req.ready;

   always_comb begin
      if (radix_ff < itra_pkg::RADIX_MIN) begin
         base = itra_pkg::RADIX_MIN;
      end else if (radix_ff > itra_pkg::RADIX_MAX) begin
         base = itra_pkg::RADIX_MAX;
      end else begin
         base = radix_ff;
      end
      // only decimal shows a sign
      sign          = (base == itra_pkg::DECIMAL) && req.value[itra_pkg::VALUE_W-1];
      job.base      = base;
      job.sign      = sign;
      job.magnitude = sign ? (~req.value + itra_pkg::VALUE_W'(1)) : req.value;
   end

endmodule

[sv/itra_queue.sv]
module itra_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  itra_pkg::itra_job_type job_in,
   input  logic                   pop,
   output itra_pkg::itra_job_type job_out,
   output logic                   not_empty,
   output logic                   full
);

   localparam int PTR_W = $clog2(itra_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(itra_pkg::QUEUE_DEPTH + 1);

   itra_pkg::itra_job_type entry_ff [itra_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(itra_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign job_out   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(itra_pkg::QUEUE_DEPTH - 1)) ? '0
                         : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(itra_pkg::QUEUE_DEPTH - 1)) ? '0
                         : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

[sv/itra_back.sv]
module itra_back #(
   parameter int MAX_DIGITS = itra_pkg::MAX_DIGITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  itra_pkg::itra_job_type job,
   output logic                   pop,
   itra_rsp_if.source             rsp
);

   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int VW    = itra_pkg::VALUE_W;
   localparam int RW    = itra_pkg::RADIX_W;
   localparam int BW    = itra_pkg::BIT_CNT_W;

   typedef enum logic [2:0] {
      IDLE,
      DIVIDE,
      SIGN,
      FETCH,
      EMIT
   } state_type;

   state_type                   state_ff;
   logic [VW-1:0]               quot_ff;
   logic [RW-1:0]               rem_ff;
   logic [RW-1:0]               base_ff;
   logic                        sign_ff;
   logic [BW-1:0]               bit_cnt_ff;
   logic [CNT_W-1:0]            count_ff;
   logic [IDX_W-1:0]            idx_ff;
   logic [RW-1:0]               rd_data_ff;
   logic                        rsp_valid_ff;
   logic [itra_pkg::CHAR_W-1:0] char_ff;
   logic                        last_ff;

   logic [RW-1:0]               digit_store [MAX_DIGITS];

   logic [RW:0]                 rem_shift;
   logic                        ge;
   logic [RW-1:0]               rem_in;
   logic [VW-1:0]               quot_in;
   logic [CNT_W-1:0]            count_in;
   logic                        out_free;
   logic                        digit_done;
   logic                        emit_load;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_shift  = {rem_ff, quot_ff[VW-1]};
      ge         = (rem_shift >= {1'b0, base_ff});
      rem_in     = ge ? RW'(rem_shift - {1'b0, base_ff}) : rem_shift[RW-1:0];
      quot_in    = {quot_ff[VW-2:0], ge};
      count_in   = count_ff + CNT_W'(1);
      digit_done = (state_ff == DIVIDE) && (bit_cnt_ff == BW'(VW - 1));
      out_free   = !rsp_valid_ff || rsp.ready;
      emit_load  = out_free && (state_ff == SIGN || state_ff == EMIT);
   end

   assign pop           = (state_ff == IDLE) && job_valid;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.char_code = char_ff;
   assign rsp.last_char = last_ff;

   always_ff @(posedge clock) begin
      if (digit_done) begin
         digit_store[count_ff[IDX_W-1:0]] <= rem_in;
      end
      rd_data_ff <= digit_store[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         bit_cnt_ff   <= '0;
         idx_ff       <= '0;
         sign_ff      <= 1'b0;
      end else begin
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (job_valid) begin
                  quot_ff    <= job.magnitude;
                  base_ff    <= job.base;
                  sign_ff    <= job.sign;
                  rem_ff     <= '0;
                  bit_cnt_ff <= '0;
                  count_ff   <= '0;
                  state_ff   <= DIVIDE;
               end
            end
            DIVIDE: begin
               bit_cnt_ff <= bit_cnt_ff + BW'(1);
               if (digit_done) begin
                  count_ff <= count_in;
                  idx_ff   <= count_ff[IDX_W-1:0];
                  rem_ff   <= '0;
                  quot_ff  <= quot_in;
                  if (quot_in == '0 || count_in >= CNT_W'(MAX_DIGITS)) begin
                     state_ff <= sign_ff ? SIGN : FETCH;
                  end
               end else begin
                  rem_ff  <= rem_in;
                  quot_ff <= quot_in;
               end
            end
            SIGN: begin
               if (out_free) begin
                  char_ff      <= itra_pkg::CHAR_MINUS;
                  last_ff      <= 1'b0;
                  state_ff     <= FETCH;
               end
            end
            FETCH: begin
               state_ff <= EMIT;
            end
            EMIT: begin
               if (out_free) begin
                  char_ff      <= itra_pkg::digit_char(rd_data_ff);
                  last_ff      <= (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_ff <= IDLE;
                  end else begin
                     idx_ff   <= idx_ff - IDX_W'(1);
                     state_ff <= FETCH;
                  end
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule

[sv/integer_to_radix_ascii_top.sv]
// Integer to ASCII text converter, radix 2 to 36.
// req: one 32-bit signed value per request. rsp: one ASCII character per
// transfer, most significant digit first, last_char set on the final one.
// csr: write-only radix register (reset 10); codes below 2 act as 2, above
// 36 as 36. Write it only while no request is in flight.
// In radix 10 a negative value is sent as '-' and its magnitude; in other
// radices the 32-bit pattern is taken as unsigned.
// The serial divider, one for all requests, works out one digit at a time,
// least significant first, into a digit store; only when all digits are
// done is a leading '-' sent, then each digit is read back from the store
// in a fetch step and loaded into the output register, most significant
// first.
// A two-entry queue sits between the request side and the divider, so up
// to two further requests are taken while one is being converted.
// When the receiver stalls, the current character holds in the output
// register and the converter waits; the queue keeps taking requests until
// full. Synchronous reset empties the queue, drops any pending character
// and restores radix 10.
module integer_to_radix_ascii_top #(
   parameter int MAX_DIGITS = itra_pkg::MAX_DIGITS
) (
   input logic        clock,
   input logic        reset,
   itra_req_if.sink   req,
   itra_rsp_if.source rsp,
   itra_csr_if.sink   csr
);

   itra_pkg::itra_job_type front_job;
   itra_pkg::itra_job_type queue_job;
   logic                   push;
   logic                   pop;
   logic                   queue_full;
   logic                   queue_valid;

   itra_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr        (csr),
      .queue_full (queue_full),
      .push       (push),
      .job        (front_job)
   );

   itra_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .job_in    (front_job),
      .pop       (pop),
      .job_out   (queue_job),
      .not_empty (queue_valid),
      .full      (queue_full)
   );

   itra_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_valid),
      .job       (queue_job),
      .pop       (pop),
      .rsp       (rsp)
   );

endmodule

[sv/itra_checker.sv]
module itra_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [itra_pkg::CHAR_W-1:0] rsp_char_code,
   input logic                        rsp_last_char
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped under stall");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_char_code) && $stable(rsp_last_char))
      else $error("rsp payload changed under stall");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_code == itra_pkg::CHAR_MINUS) ||
                    (rsp_char_code >= 7'h30 && rsp_char_code <= 7'h39) ||
                    (rsp_char_code >= 7'h41 && rsp_char_code <= 7'h5A))
      else $error("illegal character code");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_code == itra_pkg::CHAR_MINUS |-> !rsp_last_char)
      else $error("sign sent as last character");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind integer_to_radix_ascii_top itra_checker u_itra_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_char_code (rsp.char_code),
   .rsp_last_char (rsp.last_char)
);
